// ===== hw/rtl/mq_arithmetic_encoder_unit_macros.svh =====
// Assertion macros for the MQ encoder unit
`ifndef MQ_ARITHMETIC_ENCODER_UNIT_MACROS_SVH
`define MQ_ARITHMETIC_ENCODER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define MQ_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
// next-cycle implication
`define MQ_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`endif

// ===== hw/rtl/mqe_pkg.sv =====
// Types, constants and probability tables of the MQ encoder
package mqe_pkg;
    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_SETCX = 3'd1,
        CMD_ENC   = 3'd2,
        CMD_FLUSH = 3'd3,
        CMD_TERM  = 3'd4,
        CMD_SEG   = 3'd5
    } cmd_t;

    localparam int unsigned MAX_STATE = 46;
    localparam logic [4:0] SEG_CTX = 5'd18;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] cx;
        logic       decision;
        logic [5:0] state_index;
        logic       mps_value;
    } op_t;

    function automatic logic [15:0] qe_lut(input logic [5:0] s);
        logic [15:0] q;
        case (s)
            6'd0: q = 16'h5601;  6'd1: q = 16'h3401;  6'd2: q = 16'h1801;
            6'd3: q = 16'h0AC1;  6'd4: q = 16'h0521;  6'd5: q = 16'h0221;
            6'd6: q = 16'h5601;  6'd7: q = 16'h5401;  6'd8: q = 16'h4801;
            6'd9: q = 16'h3801;  6'd10: q = 16'h3001; 6'd11: q = 16'h2401;
            6'd12: q = 16'h1C01; 6'd13: q = 16'h1601; 6'd14: q = 16'h5601;
            6'd15: q = 16'h5401; 6'd16: q = 16'h5101; 6'd17: q = 16'h4801;
            6'd18: q = 16'h3801; 6'd19: q = 16'h3401; 6'd20: q = 16'h3001;
            6'd21: q = 16'h2801; 6'd22: q = 16'h2401; 6'd23: q = 16'h2201;
            6'd24: q = 16'h1C01; 6'd25: q = 16'h1801; 6'd26: q = 16'h1601;
            6'd27: q = 16'h1401; 6'd28: q = 16'h1201; 6'd29: q = 16'h1101;
            6'd30: q = 16'h0AC1; 6'd31: q = 16'h09C1; 6'd32: q = 16'h08A1;
            6'd33: q = 16'h0521; 6'd34: q = 16'h0441; 6'd35: q = 16'h02A1;
            6'd36: q = 16'h0221; 6'd37: q = 16'h0141; 6'd38: q = 16'h0111;
            6'd39: q = 16'h0085; 6'd40: q = 16'h0049; 6'd41: q = 16'h0025;
            6'd42: q = 16'h0015; 6'd43: q = 16'h0009; 6'd44: q = 16'h0005;
            6'd45: q = 16'h0001; default: q = 16'h5601;
        endcase
        return q;
    endfunction

    function automatic logic [5:0] nmps_lut(input logic [5:0] s);
        logic [5:0] n;
        case (s)
            6'd5: n = 6'd38;
            6'd13: n = 6'd29;
            6'd45: n = 6'd45;
            6'd46: n = 6'd46;
            default: n = s + 6'd1;
        endcase
        return n;
    endfunction

    function automatic logic [5:0] nlps_lut(input logic [5:0] s);
        logic [5:0] n;
        case (s)
            6'd0: n = 6'd1;   6'd1: n = 6'd6;   6'd2: n = 6'd9;   6'd3: n = 6'd12;
            6'd4: n = 6'd29;  6'd5: n = 6'd33;  6'd6: n = 6'd6;   6'd7: n = 6'd14;
            6'd8: n = 6'd14;  6'd9: n = 6'd14;  6'd10: n = 6'd17; 6'd11: n = 6'd18;
            6'd12: n = 6'd20; 6'd13: n = 6'd21; 6'd14: n = 6'd14; 6'd15: n = 6'd14;
            6'd16: n = 6'd15; 6'd17: n = 6'd16; 6'd18: n = 6'd17; 6'd19: n = 6'd18;
            6'd20: n = 6'd19; 6'd21: n = 6'd19; 6'd46: n = 6'd46;
            default: n = s - 6'd2;
        endcase
        return n;
    endfunction

    function automatic logic swap_lut(input logic [5:0] s);
        return (s == 6'd0) || (s == 6'd6) || (s == 6'd14);
    endfunction
endpackage

// ===== hw/rtl/mqe_front.sv =====
// Front end: accepts command beats, drops ignored ones, expands segment markers
module mqe_front #(
    parameter int NUM_CONTEXTS = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             stall,
    input  logic [2:0]       command,
    input  logic [4:0]       context_req,
    input  logic             decision,
    input  logic [5:0]       state_index,
    input  logic             mps_value,
    output logic             q_valid,
    input  logic             q_ready,
    output mqe_pkg::op_t     q_op
);
    import mqe_pkg::*;

    localparam int QD = 2;

    op_t        fifo_reg [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] seg_reg;
    logic       seg_busy_reg;
    logic [1:0] seg_next;
    logic       seg_busy_next;
    logic       acc, keep, push, pop, full;
    op_t        pin;

    assign full  = (cnt_reg == 2'(QD));
    assign stall = full || seg_busy_reg;
    assign acc   = valid && !stall;

    always_comb
    begin
        keep = 1'b0;
        case (command)
            CMD_INIT, CMD_FLUSH, CMD_TERM, CMD_SEG: keep = 1'b1;
            CMD_SETCX, CMD_ENC: keep = (32'(context_req) < NUM_CONTEXTS);
            default: keep = 1'b0;
        endcase
    end

    always_comb
    begin
        pin = '0;
        seg_next = seg_reg;
        seg_busy_next = seg_busy_reg;
        push = 1'b0;
        if (seg_busy_reg)
        begin
            if (!full)
            begin
                push = 1'b1;
                pin.command = CMD_SEG;
                pin.cx = SEG_CTX;
                pin.decision = ~seg_reg[0];
                pin.mps_value = (seg_reg == 2'd3);
                seg_next = seg_reg + 2'd1;
                if (seg_reg == 2'd3)
                    seg_busy_next = 1'b0;
            end
        end
        else if (acc && keep)
        begin
            push = 1'b1;
            pin.command = command;
            pin.cx = context_req;
            pin.decision = decision;
            pin.state_index = (state_index > 6'(MAX_STATE)) ? 6'(MAX_STATE) : state_index;
            pin.mps_value = mps_value;
            if (command == CMD_SEG)
            begin
                pin.cx = SEG_CTX;
                pin.decision = 1'b1;
                pin.mps_value = 1'b0;
                seg_next = 2'd1;
                seg_busy_next = 1'b1;
            end
        end
    end

    assign pop     = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= pin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            seg_reg <= '0;
            seg_busy_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            seg_reg <= seg_next;
            seg_busy_reg <= seg_busy_next;
        end
    end
endmodule

// ===== hw/rtl/mqe_back.sv =====
// Back end: coding registers, context table, renormalisation and byte output
module mqe_back #(
    parameter int NUM_CONTEXTS = 19
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  mqe_pkg::op_t   q_op,
    output logic           valid,
    input  logic           stall,
    output logic [7:0]     out_byte,
    output logic           last
);
    import mqe_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_REN   = 5'b00010,
        S_FL    = 5'b00100,
        S_TERM  = 5'b01000,
        S_FIN   = 5'b10000
    } st_t;

    localparam int CXW = $clog2(NUM_CONTEXTS);

    st_t         st_reg, st_next;
    logic [15:0] a_reg, a_next;
    logic [27:0] c_reg, c_next;
    logic [3:0]  ct_reg, ct_next;
    logic [7:0]  b_reg, b_next;
    logic        bv_reg, bv_next;
    logic [5:0]  cst_reg [NUM_CONTEXTS];
    logic        cmps_reg [NUM_CONTEXTS];
    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  tk_reg, tk_next;
    logic        seg_reg, seg_next;
    logic        ob_full_reg, ob_full_next;
    logic [7:0]  ob_byte_reg, ob_byte_next;
    logic        ob_last_reg, ob_last_next;
    logic        hold_reg, hold_next;
    logic [7:0]  hb_reg, hb_next;
    logic        cx_we;
    logic [CXW-1:0] cx_wa;
    logic [5:0]  cx_ws;
    logic        cx_wm;
    logic        em_go;

    // one byte-out step on given C / pending, result into *_bo
    logic [27:0] c_bo;
    logic [7:0]  b_bo;
    logic [3:0]  ct_bo;
    logic        em_bo;
    logic [7:0]  emb_bo;

    function automatic void byteout(input logic [27:0] c, input logic [7:0] b,
                                    input logic bv, output logic [27:0] co,
                                    output logic [7:0] bo, output logic [3:0] cto,
                                    output logic em, output logic [7:0] emb);
        logic [7:0] bb;
        logic [27:0] cc;
        bb = b;
        cc = c;
        if (b != 8'hFF && c[27])
        begin
            bb = b + 8'd1;
            if (bb == 8'hFF)
                cc[27] = 1'b0;
        end
        em = bv;
        emb = bb;
        if (bb == 8'hFF)
        begin
            bo = cc[27:20];
            co = {8'd0, cc[19:0]};
            cto = 4'd7;
        end
        else
        begin
            bo = cc[26:19];
            co = {9'd0, cc[18:0]};
            cto = 4'd8;
        end
    endfunction

    logic [27:0] c_src;
    assign c_src = (st_reg == S_REN) ? {c_reg[26:0], 1'b0} :
                   (st_reg == S_TERM && (tk_reg == 5'd0 || tk_reg[4])) ? c_reg :
                   (c_reg << ct_reg);

    always_comb
    begin
        byteout(c_src, b_reg, bv_reg, c_bo, b_bo, ct_bo, em_bo, emb_bo);
    end

    logic out_free;
    assign out_free = !ob_full_reg || !stall;
    assign valid    = ob_full_reg;
    assign out_byte = ob_byte_reg;
    assign last     = ob_last_reg;

    logic [5:0]  s;
    logic        m;
    logic [15:0] qe, am;
    logic [28:0] sum;
    logic [27:0] cf;
    logic [CXW-1:0] cxi;

    assign cxi = q_op.cx[CXW-1:0];
    assign s   = cst_reg[cxi];
    assign m   = cmps_reg[cxi];
    assign qe  = qe_lut(s);
    assign am  = a_reg - qe;

    assign q_ready = (st_reg == S_IDLE) && !(hold_reg && !seg_reg) && out_free;

    always_comb
    begin
        st_next = st_reg;
        a_next = a_reg; c_next = c_reg; ct_next = ct_reg;
        b_next = b_reg; bv_next = bv_reg;
        phase_next = phase_reg; tk_next = tk_reg; seg_next = seg_reg;
        ob_full_next = ob_full_reg && stall;
        ob_byte_next = ob_byte_reg; ob_last_next = ob_last_reg;
        hold_next = hold_reg; hb_next = hb_reg;
        cx_we = 1'b0; cx_wa = cxi; cx_ws = s; cx_wm = m;
        sum = '0; cf = '0;
        em_go = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (hold_reg && !seg_reg && out_free)
                begin
                    ob_full_next = 1'b1;
                    ob_byte_next = hb_reg;
                    ob_last_next = 1'b1;
                    hold_next = 1'b0;
                end
                else if (q_valid && q_ready)
                begin
                    unique case (q_op.command)
                        CMD_INIT:
                        begin
                            a_next = 16'h8000; c_next = '0; ct_next = 4'd12;
                            b_next = '0; bv_next = 1'b0;
                        end
                        CMD_SETCX:
                        begin
                            cx_we = 1'b1;
                            cx_ws = q_op.state_index;
                            cx_wm = q_op.mps_value;
                        end
                        CMD_FLUSH:
                        begin
                            sum = {1'b0, c_reg} + 29'(a_reg);
                            cf = c_reg | 28'hFFFF;
                            if ({1'b0, cf} >= sum)
                                cf = cf - 28'h8000;
                            c_next = cf;
                            phase_next = 2'd0;
                            st_next = S_FL;
                        end
                        CMD_TERM:
                        begin
                            tk_next = 5'd12 - 5'(ct_reg);
                            st_next = S_TERM;
                        end
                        default:
                        begin
                            seg_next = (q_op.command == CMD_SEG) && !q_op.mps_value;
                            cx_we = 1'b1;
                            if (q_op.decision == m)
                            begin
                                if (!am[15])
                                begin
                                    if (am < qe) a_next = qe;
                                    else
                                    begin
                                        a_next = am;
                                        c_next = c_reg + 28'(qe);
                                    end
                                    cx_ws = nmps_lut(s);
                                    st_next = S_REN;
                                end
                                else
                                begin
                                    a_next = am;
                                    c_next = c_reg + 28'(qe);
                                    st_next = S_FIN;
                                end
                            end
                            else
                            begin
                                if (am < qe)
                                begin
                                    a_next = am;
                                    c_next = c_reg + 28'(qe);
                                end
                                else
                                    a_next = qe;
                                if (swap_lut(s)) cx_wm = ~m;
                                cx_ws = nlps_lut(s);
                                st_next = S_REN;
                            end
                        end
                    endcase
                end
            end
            S_REN:
            begin
                if (out_free)
                begin
                    a_next = {a_reg[14:0], 1'b0};
                    ct_next = ct_reg - 4'd1;
                    c_next = {c_reg[26:0], 1'b0};
                    if (ct_reg == 4'd1)
                    begin
                        c_next = c_bo; b_next = b_bo; ct_next = ct_bo; bv_next = 1'b1;
                        if (em_bo)
                        begin
                            if (hold_reg)
                            begin
                                ob_full_next = 1'b1;
                                ob_byte_next = hb_reg;
                                ob_last_next = 1'b0;
                            end
                            hold_next = 1'b1;
                            hb_next = emb_bo;
                        end
                    end
                    if (a_reg[14])
                        st_next = S_FIN;
                end
            end
            S_FL:
            begin
                if (out_free)
                begin
                    if (phase_reg != 2'd2)
                    begin
                        c_next = c_bo; b_next = b_bo; ct_next = ct_bo; bv_next = 1'b1;
                        if (em_bo)
                        begin
                            if (hold_reg)
                            begin
                                ob_full_next = 1'b1;
                                ob_byte_next = hb_reg;
                                ob_last_next = 1'b0;
                            end
                            hold_next = 1'b1;
                            hb_next = emb_bo;
                        end
                        phase_next = phase_reg + 2'd1;
                    end
                    else
                    begin
                        if (bv_reg && b_reg != 8'hFF)
                        begin
                            if (hold_reg)
                            begin
                                ob_full_next = 1'b1;
                                ob_byte_next = hb_reg;
                                ob_last_next = 1'b0;
                            end
                            hold_next = 1'b1;
                            hb_next = b_reg;
                        end
                        b_next = '0; bv_next = 1'b0;
                        st_next = S_IDLE;
                    end
                end
            end
            S_TERM:
            begin
                if (out_free)
                begin
                    em_go = em_bo;
                    if (tk_reg != 5'd0 && !tk_reg[4])
                    begin
                        c_next = c_bo; b_next = b_bo; ct_next = ct_bo; bv_next = 1'b1;
                        tk_next = tk_reg - 5'(ct_bo);
                    end
                    else
                    begin
                        if (b_reg != 8'hFF)
                        begin
                            c_next = c_bo;
                            ct_next = ct_bo;
                        end
                        else
                            em_go = 1'b0;
                        b_next = '0; bv_next = 1'b0;
                        st_next = S_IDLE;
                    end
                    if (em_go)
                    begin
                        if (hold_reg)
                        begin
                            ob_full_next = 1'b1;
                            ob_byte_next = hb_reg;
                            ob_last_next = 1'b0;
                        end
                        hold_next = 1'b1;
                        hb_next = emb_bo;
                    end
                end
            end
            S_FIN: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ob_byte_reg <= ob_byte_next;
        ob_last_reg <= ob_last_next;
        hb_reg <= hb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            bv_reg <= 1'b0;
            ob_full_reg <= 1'b0;
            hold_reg <= 1'b0;
            a_reg <= 16'h8000;
            c_reg <= '0;
            ct_reg <= 4'd12;
            b_reg <= '0;
            phase_reg <= '0;
            tk_reg <= '0;
            seg_reg <= 1'b0;
            for (int i = 0; i < NUM_CONTEXTS; i++)
            begin
                cst_reg[i] <= '0;
                cmps_reg[i] <= 1'b0;
            end
        end
        else
        begin
            st_reg <= st_next;
            bv_reg <= bv_next;
            ob_full_reg <= ob_full_next;
            hold_reg <= hold_next;
            a_reg <= a_next; c_reg <= c_next; ct_reg <= ct_next; b_reg <= b_next;
            phase_reg <= phase_next; tk_reg <= tk_next; seg_reg <= seg_next;
            if (cx_we)
            begin
                cst_reg[cx_wa] <= cx_ws;
                cmps_reg[cx_wa] <= cx_wm;
            end
        end
    end
endmodule

// ===== hw/rtl/mq_arithmetic_encoder_unit.sv =====
// Top level of the MQ arithmetic encoder unit
// Usage:
//   Input channel (valid / stall) carries one command beat: init, set
//   context, encode, flush, predictable termination or segment marker.
//   Output channel (valid / stall) carries finished code bytes; last marks
//   the final byte that a command produced.
//   A command enters a two-entry queue in the front end; the back end takes
//   it when idle. An encode does up to 15 renormalising shifts and a finish
//   step; flush two byte-out steps and a final one; termination byte-out steps.
//   A segment marker expands into four encodes in context 18.
//   The last byte of a command is held back until the command ends, so it
//   is output only after its command completes.
//   The renormalisation loop, one bit per cycle while the output is not stalled, sets the rate.
//   Reset clears the coder to interval 0x8000, countdown 12 and no pending
//   byte, and sets every context to state 0 with MPS 0; init keeps the
//   context table.
//   A stall on a waiting output byte holds the back end; the queue then fills and the
//   input stall rises.
module mq_arithmetic_encoder_unit #(
    parameter int NUM_CONTEXTS = 19
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] command,
    input  logic [4:0] context_req,
    input  logic       decision,
    input  logic [5:0] state_index,
    input  logic       mps_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last
);
    import mqe_pkg::*;
    `include "mq_arithmetic_encoder_unit_macros.svh"

    logic q_valid, q_ready;
    op_t  q_op;

    mqe_front #(.NUM_CONTEXTS(NUM_CONTEXTS)) u_front (
        .clk, .rst_n, .valid(in_valid), .stall(in_stall), .command, .context_req,
        .decision, .state_index, .mps_value, .q_valid, .q_ready, .q_op
    );

    mqe_back #(.NUM_CONTEXTS(NUM_CONTEXTS)) u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_op, .valid(out_valid),
        .stall(out_stall), .out_byte, .last
    );

    `MQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
        "output beat dropped under stall")
    `MQ_ASSERT_NEXT(a_byte_hold, clk, rst_n, out_valid && out_stall,
        $stable(out_byte), "output byte changed under stall")
    `MQ_ASSERT_NEXT(a_last_hold, clk, rst_n, out_valid && out_stall,
        $stable(last), "last flag changed under stall")
endmodule
